// ===== hdl/imq_pkg.sv =====
// Shared types, codes and defaults for the indexed multi-queue block.
package imq_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ITEM_BITS_DEF   = 16;

    localparam int ITEM_W   = 16;
    localparam int QNUM_W   = 8;
    localparam int LEN_W    = 5;
    localparam int ACTIVE_W = 4;

    // Depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Bits needed to index n entries (at least one)
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DEQUEUED  = 3'd1,
        ST_BAD_QUEUE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [QNUM_W-1:0]  queue_number;
        logic [ITEM_W-1:0]  item_id;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [ITEM_W-1:0]  departed_item;
        logic [LEN_W-1:0]   queue_length;
    } t_res_item;

    // Classified operation handed from front to back
    typedef struct packed {
        t_status            status;
        logic [LEN_W-1:0]   queue_length;
        logic [ITEM_W-1:0]  item_id;
    } t_cmd_info;

endpackage

// ===== hdl/imq_front.sv =====
// Front end: accepts operations, checks them against the queue pointers and updates them.
module imq_front #(
    parameter int NUM_QUEUES  = imq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = imq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [imq_pkg::ACTIVE_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    input  imq_pkg::t_in_item                 i_in,
    input  logic                              i_cmd_ready,
    output logic                              o_in_ready,
    output logic                              o_cmd_valid,
    output imq_pkg::t_cmd_info                o_cmd_info,
    output logic [imq_pkg::idx_bits(NUM_QUEUES)-1:0]  o_cmd_queue,
    output logic [imq_pkg::idx_bits(QUEUE_DEPTH)-1:0] o_cmd_slot
);
    localparam int QW = imq_pkg::idx_bits(NUM_QUEUES);
    localparam int SW = imq_pkg::idx_bits(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [imq_pkg::ACTIVE_W-1:0] r_active;
    logic [SW-1:0]                r_head [NUM_QUEUES];
    logic [FW-1:0]                r_fill [NUM_QUEUES];

    logic           w_accept;
    logic           w_qn_ok;
    logic [QW-1:0]  w_q;
    logic [SW-1:0]  w_head;
    logic [FW-1:0]  w_fill;
    logic [FW:0]    w_sum;
    logic [SW-1:0]  w_tail;
    logic [SW-1:0]  w_head_next;
    logic           w_push_ok;
    logic           w_pop_ok;

    assign w_accept   = i_in_valid && i_cmd_ready;
    assign o_in_ready = i_cmd_ready;
    assign o_cmd_valid = i_in_valid;

    assign w_qn_ok = (i_in.queue_number != '0)
                  && (i_in.queue_number <= imq_pkg::QNUM_W'(r_active))
                  && (int'(i_in.queue_number) <= NUM_QUEUES);
    assign w_q     = QW'(i_in.queue_number - imq_pkg::QNUM_W'(1));
    assign w_head  = r_head[w_q];
    assign w_fill  = r_fill[w_q];

    // Tail slot is head plus fill, wrapped once
    assign w_sum  = (FW+1)'(w_head) + (FW+1)'(w_fill);
    assign w_tail = (w_sum >= (FW+1)'(QUEUE_DEPTH)) ? SW'(w_sum - (FW+1)'(QUEUE_DEPTH))
                                                    : SW'(w_sum);
    assign w_head_next = (w_head == SW'(QUEUE_DEPTH - 1)) ? '0 : w_head + SW'(1);

    assign w_push_ok = w_qn_ok && (i_in.op == imq_pkg::OP_ENQUEUE)
                    && (w_fill != FW'(QUEUE_DEPTH));
    assign w_pop_ok  = w_qn_ok && (i_in.op == imq_pkg::OP_DEQUEUE) && (w_fill != '0);

    always_comb begin
        o_cmd_info.item_id      = i_in.item_id;
        o_cmd_info.status       = imq_pkg::ST_BAD_QUEUE;
        o_cmd_info.queue_length = '0;
        o_cmd_slot              = w_tail;
        if (w_qn_ok) begin
            case (i_in.op)
                imq_pkg::OP_ENQUEUE: begin
                    if (w_push_ok) begin
                        o_cmd_info.status       = imq_pkg::ST_ENQUEUED;
                        o_cmd_info.queue_length = imq_pkg::LEN_W'(w_fill + FW'(1));
                    end else begin
                        o_cmd_info.status       = imq_pkg::ST_FULL;
                        o_cmd_info.queue_length = imq_pkg::LEN_W'(w_fill);
                    end
                end
                imq_pkg::OP_DEQUEUE: begin
                    o_cmd_slot = w_head;
                    if (w_pop_ok) begin
                        o_cmd_info.status       = imq_pkg::ST_DEQUEUED;
                        o_cmd_info.queue_length = imq_pkg::LEN_W'(w_fill - FW'(1));
                    end else begin
                        o_cmd_info.status       = imq_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    o_cmd_info.status = imq_pkg::ST_BAD_QUEUE;
                end
            endcase
        end
    end

    assign o_cmd_queue = w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= imq_pkg::ACTIVE_W'(8);
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            if (w_accept && w_push_ok) begin
                r_fill[w_q] <= w_fill + FW'(1);
            end
            if (w_accept && w_pop_ok) begin
                r_head[w_q] <= w_head_next;
                r_fill[w_q] <= w_fill - FW'(1);
            end
        end
    end

    a_bad_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd_info.status == imq_pkg::ST_BAD_QUEUE)
            |-> (o_cmd_info.queue_length == '0))
        else $error("bad queue number reported with nonzero length");

    a_deq_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_pop_ok) |=> (r_fill[$past(w_q)] == $past(w_fill) - FW'(1)))
        else $error("fill count not reduced after dequeue");

    a_enq_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_push_ok) |-> (w_fill < FW'(QUEUE_DEPTH)))
        else $error("enqueue accepted onto full queue");

endmodule

// ===== hdl/imq_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module imq_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = imq_pkg::CMDQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);
    localparam int PW = imq_pkg::idx_bits(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("command queue overfilled");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("transfer into command queue not counted");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("transfer out of command queue not counted");

endmodule

// ===== hdl/imq_back.sv =====
// Back end: carries out item store writes and reads and holds the result register.
module imq_back #(
    parameter int NUM_QUEUES  = imq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = imq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BITS   = imq_pkg::ITEM_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cmd_valid,
    input  imq_pkg::t_cmd_info                        i_cmd_info,
    input  logic [imq_pkg::idx_bits(NUM_QUEUES)-1:0]  i_cmd_queue,
    input  logic [imq_pkg::idx_bits(QUEUE_DEPTH)-1:0] i_cmd_slot,
    output logic                                      o_cmd_ready,
    output logic                                      o_res_valid,
    output imq_pkg::t_res_item                        o_res,
    input  logic                                      i_res_ready
);
    localparam int STORE_W = (ITEM_BITS < imq_pkg::ITEM_W) ? ITEM_BITS : imq_pkg::ITEM_W;

    logic [STORE_W-1:0] r_store [NUM_QUEUES][QUEUE_DEPTH];
    logic [STORE_W-1:0] r_rd_data;
    logic               r_out_valid;
    imq_pkg::t_cmd_info r_out_info;

    logic w_take;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign w_take      = i_cmd_valid && o_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (i_cmd_info.status == imq_pkg::ST_ENQUEUED) begin
                r_store[i_cmd_queue][i_cmd_slot] <= i_cmd_info.item_id[STORE_W-1:0];
            end
            if (i_cmd_info.status == imq_pkg::ST_DEQUEUED) begin
                r_rd_data <= r_store[i_cmd_queue][i_cmd_slot];
            end
            r_out_info <= i_cmd_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res_valid          = r_out_valid;
    assign o_res.status         = r_out_info.status;
    assign o_res.queue_length   = r_out_info.queue_length;
    assign o_res.departed_item  = (r_out_info.status == imq_pkg::ST_DEQUEUED)
                                ? imq_pkg::ITEM_W'(r_rd_data) : '0;

    a_item_only_on_dequeue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != imq_pkg::ST_DEQUEUED) |-> (o_res.departed_item == '0))
        else $error("departed item set on a result other than dequeue");

    a_take_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("command taken but no result held");

    a_no_take_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |-> !w_take)
        else $error("result overwritten while stalled");

endmodule

// ===== hdl/indexed_multi_queue.sv =====
// Top level of the indexed multi-queue block.
// A bank of NUM_QUEUES FIFO queues of QUEUE_DEPTH items each, addressed by a 1-based queue
// number; every operation (enqueue or dequeue) gives exactly one result with a status and the
// queue's length afterwards. While the result side keeps up, the block sustains one operation
// per clock: the front end checks and updates the per-queue head and fill registers in the
// cycle of the transfer, and the back end makes one item store access per cycle. A result
// passes through the command queue and then the result register before it is presented, and
// waits there while the result side stalls. Either side may stall without stopping the other
// until the two-entry command queue between them and the result register are all occupied,
// after which the input stalls too. The active_queues register must be written through the
// config channel only while idle, which the block does not enforce; its reset value is 8.
module indexed_multi_queue #(
    parameter int NUM_QUEUES  = imq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = imq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BITS   = imq_pkg::ITEM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [imq_pkg::ACTIVE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  imq_pkg::t_in_item             i_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output imq_pkg::t_res_item            o_res
);
    localparam int QW    = imq_pkg::idx_bits(NUM_QUEUES);
    localparam int SW    = imq_pkg::idx_bits(QUEUE_DEPTH);
    localparam int CMD_W = $bits(imq_pkg::t_cmd_info) + QW + SW;

    logic               w_push_valid;
    logic               w_push_ready;
    imq_pkg::t_cmd_info w_push_info;
    logic [QW-1:0]      w_push_queue;
    logic [SW-1:0]      w_push_slot;

    logic               w_pop_valid;
    logic               w_pop_ready;
    logic [CMD_W-1:0]   w_pop_data;
    imq_pkg::t_cmd_info w_pop_info;
    logic [QW-1:0]      w_pop_queue;
    logic [SW-1:0]      w_pop_slot;

    assign o_cfg_ready = 1'b1;

    imq_front #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_cmd_ready (w_push_ready),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (w_push_valid),
        .o_cmd_info  (w_push_info),
        .o_cmd_queue (w_push_queue),
        .o_cmd_slot  (w_push_slot)
    );

    imq_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (imq_pkg::CMDQ_DEPTH)
    ) u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  ({w_push_info, w_push_queue, w_push_slot}),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_data),
        .i_pop_ready  (w_pop_ready)
    );

    assign {w_pop_info, w_pop_queue, w_pop_slot} = w_pop_data;

    imq_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_BITS   (ITEM_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .i_cmd_info  (w_pop_info),
        .i_cmd_queue (w_pop_queue),
        .i_cmd_slot  (w_pop_slot),
        .o_cmd_ready (w_pop_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_ready (i_res_ready)
    );

endmodule

// ===== dv/imq_result_checker.sv =====
// Result checker for the indexed multi-queue: tracks queue contents and compares every result.
`timescale 1ns / 1ps

module imq_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [imq_pkg::ACTIVE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  imq_pkg::t_in_item             i_in,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  imq_pkg::t_res_item            i_res,
    output int                            o_pending,
    output int                            o_fail_count
);

    localparam int NQ    = imq_pkg::NUM_QUEUES_DEF;
    localparam int DEPTH = imq_pkg::QUEUE_DEPTH_DEF;

    logic [imq_pkg::ITEM_W-1:0]   queue_store [NQ][DEPTH];
    int                           queue_head  [NQ];
    int                           queue_fill  [NQ];
    logic [imq_pkg::ACTIVE_W-1:0] active_count;

    imq_pkg::t_res_item outcome_fifo [$];
    imq_pkg::t_res_item want;
    int                 fails = 0;

    // Apply one operation to the tracked queues and give the result it should produce.
    function automatic imq_pkg::t_res_item apply_queue_op(input imq_pkg::t_in_item it);
        imq_pkg::t_res_item r;
        int                 limit;
        int                 q;
        r.status        = imq_pkg::ST_BAD_QUEUE;
        r.departed_item = '0;
        r.queue_length  = '0;
        limit = (active_count > NQ) ? NQ : int'(active_count);
        if (it.queue_number == 0 || int'(it.queue_number) > limit)
            return r;
        q = int'(it.queue_number) - 1;
        if (it.op == imq_pkg::OP_ENQUEUE) begin
            if (queue_fill[q] >= DEPTH) begin
                r.status       = imq_pkg::ST_FULL;
                r.queue_length = imq_pkg::LEN_W'(queue_fill[q]);
            end else begin
                queue_store[q][(queue_head[q] + queue_fill[q]) % DEPTH] = it.item_id;
                queue_fill[q]++;
                r.status       = imq_pkg::ST_ENQUEUED;
                r.queue_length = imq_pkg::LEN_W'(queue_fill[q]);
            end
        end else if (queue_fill[q] == 0) begin
            r.status = imq_pkg::ST_EMPTY;
        end else begin
            r.departed_item = queue_store[q][queue_head[q]];
            queue_head[q]   = (queue_head[q] + 1) % DEPTH;
            queue_fill[q]--;
            r.status        = imq_pkg::ST_DEQUEUED;
            r.queue_length  = imq_pkg::LEN_W'(queue_fill[q]);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                queue_head[q] = 0;
                queue_fill[q] = 0;
            end
            active_count = imq_pkg::ACTIVE_W'(8);
            outcome_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                active_count = i_cfg_data;
            if (i_in_valid && i_in_ready)
                outcome_fifo = {outcome_fifo, apply_queue_op(i_in)};
            if (i_res_valid && i_res_ready) begin
                if (outcome_fifo.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d item %0h len %0d",
                           i_res.status, i_res.departed_item, i_res.queue_length);
                    fails++;
                end else begin
                    want = outcome_fifo.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        fails++;
                    end
                    if (i_res.departed_item !== want.departed_item) begin
                        $error("departed_item: expected %0h, got %0h",
                               want.departed_item, i_res.departed_item);
                        fails++;
                    end
                    if (i_res.queue_length !== want.queue_length) begin
                        $error("queue_length: expected %0d, got %0d",
                               want.queue_length, i_res.queue_length);
                        fails++;
                    end
                end
            end
        end
        // Publish after the edge so the stimulus side reads a settled count
        o_pending    <= outcome_fifo.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_indexed_multi_queue.sv =====
// Testbench top for the indexed multi-queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_indexed_multi_queue;

    localparam int  CLK_HALF   = 2;
    localparam int  NQ         = imq_pkg::NUM_QUEUES_DEF;
    localparam int  DEPTH      = imq_pkg::QUEUE_DEPTH_DEF;
    localparam int  SETTLE     = 4;
    localparam int  NUM_PHASES = 7;
    localparam time TIMEOUT_NS = 2_000_000;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [imq_pkg::ACTIVE_W-1:0] i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    imq_pkg::t_in_item            i_in        = '0;
    logic                         o_res_valid;
    logic                         i_res_ready = 1'b0;
    imq_pkg::t_res_item           o_res;

    int pending;
    int fail_count;

    // Stimulus state
    int          eff_queues = 8;
    int          burst_left = 0;
    int          seg_left   = 0;
    int          enq_bias   = 50;
    int          hot_queue  = 1;
    logic [15:0] stall_tick = '0;

    always #CLK_HALF i_clk = ~i_clk;

    indexed_multi_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    imq_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_res        (o_res),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Receiver: rotate through always-ready, light, periodic heavy and coin-flip stalls
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0: i_res_ready <= 1'b1;
            2'd1: i_res_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_res_ready <= (stall_tick[2:0] < 3'd2);
            default: i_res_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic imq_pkg::t_in_item make_op(input imq_pkg::t_op op, input int qn,
                                                  input int id);
        imq_pkg::t_in_item it;
        it.op           = op;
        it.queue_number = imq_pkg::QNUM_W'(qn);
        it.item_id      = imq_pkg::ITEM_W'(id);
        return it;
    endfunction

    // Aim nine in twenty operations at a hot queue so queues run full and empty; sprinkle bad numbers.
    function automatic imq_pkg::t_in_item random_op();
        int sel;
        int qn;
        int top_q;
        top_q = (eff_queues > 0) ? eff_queues : 1;
        sel   = $urandom_range(0, 19);
        if (sel == 0)
            qn = $urandom_range(0, 255);
        else if (sel == 1)
            qn = 0;
        else if (sel == 2)
            qn = eff_queues + 1;
        else if (sel < 12)
            qn = hot_queue;
        else
            qn = $urandom_range(1, top_q);
        return make_op(($urandom_range(0, 99) < enq_bias) ? imq_pkg::OP_ENQUEUE
                                                          : imq_pkg::OP_DEQUEUE,
                       qn, $urandom_range(0, 65535));
    endfunction

    // Hold the item until transferred, then pause at the end of a burst.
    task automatic issue_op(input imq_pkg::t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active(input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= imq_pkg::ACTIVE_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eff_queues = (value > NQ) ? NQ : value;
    endtask

    function automatic int plan_active(input int phase);
        case (phase)
            0: return 1;
            1: return 15;
            2: return 0;
            3: return 3;
            4: return 9;
            5: return 8;
            default: return $urandom_range(1, 15);
        endcase
    endfunction

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int count;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: item extremes, both operations, bad numbers, empty and full queues
        issue_op(make_op(imq_pkg::OP_ENQUEUE, 1, 16'h0000));
        issue_op(make_op(imq_pkg::OP_ENQUEUE, 8, 16'hFFFF));
        issue_op(make_op(imq_pkg::OP_DEQUEUE, 8, 16'h0000));
        issue_op(make_op(imq_pkg::OP_DEQUEUE, 1, 16'hFFFF));
        issue_op(make_op(imq_pkg::OP_DEQUEUE, 1, 16'h1234));
        issue_op(make_op(imq_pkg::OP_ENQUEUE, 0, 16'hA5A5));
        issue_op(make_op(imq_pkg::OP_DEQUEUE, 255, 16'h5A5A));
        issue_op(make_op(imq_pkg::OP_ENQUEUE, 9, 16'h0F0F));
        for (int k = 0; k <= DEPTH; k++)
            issue_op(make_op(imq_pkg::OP_ENQUEUE, 2, 16'h1000 + k));
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_active(plan_active(phase));
            count    = (eff_queues == 0) ? 100 : 300;
            seg_left = 0;
            for (int n = 0; n < count; n++) begin
                if (seg_left == 0) begin
                    seg_left  = $urandom_range(30, 120);
                    hot_queue = $urandom_range(1, (eff_queues > 0) ? eff_queues : 1);
                    case ($urandom_range(0, 2))
                        0: enq_bias = 85;
                        1: enq_bias = 15;
                        default: enq_bias = 50;
                    endcase
                end
                seg_left--;
                // Let the block drain completely halfway through each phase
                if (n == count / 2)
                    wait_idle();
                issue_op(random_op());
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
